[design/framed_csv_wheel_command_receiver_core_assert.svh]
// Assertion macros for the framed CSV wheel command receiver
`ifndef FRAMED_CSV_WHEEL_COMMAND_RECEIVER_CORE_ASSERT_SVH
`define FRAMED_CSV_WHEEL_COMMAND_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FCWR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FCWR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FCWR_ASSERT_NOW(lbl, ante, cons, msg)
`define FCWR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/fcwr_pkg.sv]
// Shared types, constants and number conversion functions of the command receiver
`timescale 1ns / 1ps
`default_nettype none
package fcwr_pkg;

	localparam int NUM_WHEELS = 4;
	localparam int CFG_ADDR_W = 3;

	// register indexes, selected by paddr[2]
	localparam logic CFG_IDX_ALPHA   = 1'b0;
	localparam logic CFG_IDX_TIMEOUT = 1'b1;

	localparam logic [16:0] ALPHA_RESET   = 17'd6554;
	localparam logic [16:0] ALPHA_ONE     = 17'h10000;
	localparam logic [31:0] TIMEOUT_RESET = 32'd100000;

	localparam logic [7:0] CH_OPEN  = 8'h3C;
	localparam logic [7:0] CH_CLOSE = 8'h3E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [15:0] INT_MAX_PART = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_INT,
		PH_FRAC,
		PH_STOP
	} fcwr_phase_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  rx_byte;
		logic [31:0] now_us;
	} fcwr_item_t;

	// round(fa * 65536 / den), den a power of ten; rcp = floor(2^(16+s) / den)
	// gives an estimate at most one low, then the half-up rounding is fixed
	// by comparing the remainder against multiples of den.
	function automatic logic [16:0] fcwr_frac_div(input logic [16:0] fa,
		input logic [16:0] rcp, input int s, input logic [16:0] den);
		logic [33:0] prod;
		logic [17:0] qe;
		logic [35:0] num;
		logic [35:0] base;
		logic [35:0] rem;
		logic [16:0] res;
		prod = 34'(fa) * 34'(rcp);
		qe   = 18'(prod >> s);
		num  = {2'b00, fa, 17'd0} + 36'(den);
		base = 36'(qe) * 36'({den, 1'b0});
		rem  = num - base;
		if (rem >= 36'({den, 2'b00})) begin
			res = 17'(qe + 18'd2);
		end else if (rem >= 36'({den, 1'b0})) begin
			res = 17'(qe + 18'd1);
		end else begin
			res = qe[16:0];
		end
		return res;
	endfunction

	function automatic logic [16:0] fcwr_frac_round(input logic [16:0] fa,
		input logic [2:0] nd);
		logic [16:0] res;
		unique case (nd)
			3'd1:    res = fcwr_frac_div(fa, 17'd104857, 4, 17'd10);
			3'd2:    res = fcwr_frac_div(fa, 17'd83886, 7, 17'd100);
			3'd3:    res = fcwr_frac_div(fa, 17'd67108, 10, 17'd1000);
			3'd4:    res = fcwr_frac_div(fa, 17'd107374, 14, 17'd10000);
			3'd5:    res = fcwr_frac_div(fa, 17'd85899, 17, 17'd100000);
			default: res = 17'd0;
		endcase
		return res;
	endfunction

	// Q16.16 value of a finished token, saturated to the signed range
	function automatic logic [31:0] fcwr_token_value(input logic neg,
		input logic [15:0] ia, input logic isat, input logic [16:0] fa,
		input logic [2:0] nd);
		logic [15:0] ip;
		logic [32:0] mag;
		logic [31:0] res;
		ip  = isat ? INT_MAX_PART : ia;
		mag = {1'b0, ip, 16'h0000} + {16'h0000, fcwr_frac_round(fa, nd)};
		if (neg) begin
			if (mag > 33'h080000000) begin
				mag = 33'h080000000;
			end
			res = 32'(33'd0 - mag);
		end else begin
			if (mag > 33'h07FFFFFFF) begin
				mag = 33'h07FFFFFFF;
			end
			res = mag[31:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[design/fcwr_in_if.sv]
// Input channel: one serial byte or tick item per handshake
`timescale 1ns / 1ps
`default_nettype none
interface fcwr_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  rx_byte;
	logic [31:0] now_us;

	modport source (output valid, cmd, rx_byte, now_us, input ready);
	modport sink (input valid, cmd, rx_byte, now_us, output ready);
endinterface
`default_nettype wire

[design/fcwr_out_if.sv]
// Output channel: targets and link status per handshake
`timescale 1ns / 1ps
`default_nettype none
interface fcwr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_front_left;
	logic signed [31:0] target_front_right;
	logic signed [31:0] target_rear_left;
	logic signed [31:0] target_rear_right;
	logic               link_alive;
	logic               frame_done;

	modport source (output valid, target_front_left, target_front_right,
		target_rear_left, target_rear_right, link_alive, frame_done, input ready);
	modport sink (input valid, target_front_left, target_front_right,
		target_rear_left, target_rear_right, link_alive, frame_done, output ready);
endinterface
`default_nettype wire

[design/fcwr_cfg.sv]
// APB register block: low-pass gain and watchdog timeout
`timescale 1ns / 1ps
`default_nettype none
module fcwr_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fcwr_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	output logic [16:0]                        alpha,
	output logic [31:0]                        timeout
);
	import fcwr_pkg::*;

	logic        wr_en;
	logic [16:0] alpha_q;
	logic [31:0] timeout_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= ALPHA_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				CFG_IDX_ALPHA:   alpha_q   <= pwdata[16:0];
				CFG_IDX_TIMEOUT: timeout_q <= pwdata;
				default:         alpha_q   <= alpha_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			CFG_IDX_ALPHA:   prdata = {15'd0, alpha_q};
			CFG_IDX_TIMEOUT: prdata = timeout_q;
			default:         prdata = 32'd0;
		endcase
	end

	assign alpha   = alpha_q;
	assign timeout = timeout_q;
endmodule
`default_nettype wire

[design/fcwr_parse.sv]
// Frame and number parser: byte items build Q16.16 commands per frame
`timescale 1ns / 1ps
`default_nettype none
module fcwr_parse #(
	parameter int BODY_BYTES      = 63,
	parameter int FRACTION_DIGITS = 5,
	parameter int CHANNELS        = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire fcwr_pkg::fcwr_item_t item,
	output logic signed [31:0]        raw_cmd [CHANNELS]
);
	import fcwr_pkg::*;

	localparam int BC_W  = $clog2(BODY_BYTES + 1);
	localparam int TI_W  = $clog2(CHANNELS + 1);
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	fcwr_phase_t ph_q, ph_d, ph_e;

	logic            in_frame_q, in_frame_d;
	logic [BC_W-1:0] bc_q, bc_d;
	logic            te_q, te_d;
	logic [TI_W-1:0] ti_q, ti_d;
	logic            neg_q, neg_d;
	logic [15:0]     ia_q, ia_d;
	logic            is_q, is_d;
	logic [16:0]     fa_q, fa_d;
	logic [2:0]      fd_q, fd_d;
	logic [31:0]     pend_q [CHANNELS];
	logic [31:0]     pend_d [CHANNELS];
	logic [31:0]     raw_q [CHANNELS];
	logic [31:0]     raw_d [CHANNELS];

	logic [7:0]  c;
	logic [3:0]  dval;
	logic        is_digit;
	logic        is_space;
	logic        byte_item;
	logic        finish;
	logic        close_frame;
	logic        int_step;
	logic [19:0] int_mac;
	logic [31:0] tok_val;

	assign c         = item.rx_byte;
	assign dval      = c[3:0];
	assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign byte_item = fire && !item.cmd;
	assign tok_val   = fcwr_token_value(neg_q, ia_q, is_q, fa_q, fd_q);

	always_comb begin
		ph_d        = ph_q;
		ph_e        = ph_q;
		in_frame_d  = in_frame_q;
		bc_d        = bc_q;
		te_d        = te_q;
		ti_d        = ti_q;
		neg_d       = neg_q;
		ia_d        = ia_q;
		is_d        = is_q;
		fa_d        = fa_q;
		fd_d        = fd_q;
		pend_d      = pend_q;
		raw_d       = raw_q;
		finish      = 1'b0;
		close_frame = 1'b0;
		int_step    = 1'b0;
		int_mac     = 20'd0;

		if (byte_item) begin
			if (c == CH_OPEN) begin
				in_frame_d = 1'b1;
				bc_d       = '0;
				te_d       = 1'b0;
				ti_d       = '0;
				ph_d       = PH_IDLE;
			end else if (c == CH_CLOSE) begin
				if (in_frame_q) begin
					finish      = 1'b1;
					close_frame = 1'b1;
				end
			end else if (in_frame_q && !te_q && (bc_q < BC_W'(BODY_BYTES))) begin
				bc_d = BC_W'(bc_q + 1'b1);
				if (c == CH_NUL) begin
					finish = 1'b1;
					te_d   = 1'b1;
				end else if (c == CH_COMMA) begin
					finish = 1'b1;
				end else begin
					if (ph_q == PH_IDLE) begin
						ph_e  = PH_START;
						neg_d = 1'b0;
						ia_d  = 16'd0;
						is_d  = 1'b0;
						fa_d  = 17'd0;
						fd_d  = 3'd0;
					end
					ph_d = ph_e;
					unique case (ph_e)
						PH_START: begin
							if (is_space) begin
								ph_d = PH_START;
							end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
								neg_d = (c == CH_MINUS);
								ph_d  = PH_INT;
							end else begin
								ph_d     = PH_INT;
								int_step = 1'b1;
							end
						end
						PH_INT: int_step = 1'b1;
						PH_FRAC: begin
							if (is_digit) begin
								if (fd_d < 3'(FRACTION_DIGITS)) begin
									fa_d = 17'(fa_d * 17'd10 + 17'(dval));
									fd_d = 3'(fd_d + 3'd1);
								end
							end else begin
								ph_d = PH_STOP;
							end
						end
						default: ph_d = ph_e;
					endcase
					if (int_step) begin
						if (is_digit) begin
							int_mac = 20'(ia_d) * 20'd10 + 20'(dval);
							if (is_d || (int_mac > 20'(INT_MAX_PART))) begin
								is_d = 1'b1;
								ia_d = INT_MAX_PART;
							end else begin
								ia_d = int_mac[15:0];
							end
						end else if (c == CH_DOT) begin
							ph_d = PH_FRAC;
						end else begin
							ph_d = PH_STOP;
						end
					end
				end
			end
		end

		// a separator, NUL or closing byte ends the token in progress
		if (finish && (ph_q != PH_IDLE)) begin
			if (ti_q < TI_W'(CHANNELS)) begin
				pend_d[ti_q[IDX_W-1:0]] = tok_val;
				ti_d = TI_W'(ti_q + 1'b1);
			end
			ph_d = PH_IDLE;
		end

		// commands not present in the frame keep their old values
		if (close_frame) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (TI_W'(i) < ti_d) begin
					raw_d[i] = pend_d[i];
				end
			end
			in_frame_d = 1'b0;
			bc_d       = '0;
			te_d       = 1'b0;
			ti_d       = '0;
			ph_d       = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			bc_q       <= '0;
			te_q       <= 1'b0;
			ti_q       <= '0;
			neg_q      <= 1'b0;
			ia_q       <= 16'd0;
			is_q       <= 1'b0;
			fa_q       <= 17'd0;
			fd_q       <= 3'd0;
			for (int i = 0; i < CHANNELS; i++) begin
				pend_q[i] <= 32'd0;
				raw_q[i]  <= 32'd0;
			end
		end else begin
			in_frame_q <= in_frame_d;
			bc_q       <= bc_d;
			te_q       <= te_d;
			ti_q       <= ti_d;
			neg_q      <= neg_d;
			ia_q       <= ia_d;
			is_q       <= is_d;
			fa_q       <= fa_d;
			fd_q       <= fd_d;
			pend_q     <= pend_d;
			raw_q      <= raw_d;
		end
	end

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			raw_cmd[i] = raw_q[i];
		end
	end
endmodule
`default_nettype wire

[design/fcwr_damp.sv]
// First-order low-pass lanes that move each target toward its command
`timescale 1ns / 1ps
`default_nettype none
module fcwr_damp #(
	parameter int CHANNELS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               tick,
	input  wire logic [16:0]        alpha,
	input  wire logic signed [31:0] raw_cmd [CHANNELS],
	output logic signed [31:0]      target_next [CHANNELS]
);
	import fcwr_pkg::*;

	logic [16:0]        alpha_eff;
	logic signed [31:0] tgt_q [CHANNELS];

	assign alpha_eff = alpha[16] ? ALPHA_ONE : alpha;

	for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
		logic signed [32:0] diff;
		logic signed [50:0] prod;
		logic signed [50:0] psum;
		logic signed [34:0] step;
		logic signed [35:0] sum;
		logic signed [31:0] sat;

		assign diff = {raw_cmd[k][31], raw_cmd[k]} - {tgt_q[k][31], tgt_q[k]};
		assign prod = diff * $signed({1'b0, alpha_eff});
		// rounds half up: floor((p + 32768) / 65536)
		assign psum = prod + 51'sd32768;
		assign step = psum[50:16];
		assign sum  = {{4{tgt_q[k][31]}}, tgt_q[k]} + {step[34], step};

		always_comb begin
			if (sum > 36'sd2147483647) begin
				sat = 32'sh7FFFFFFF;
			end else if (sum < -36'sd2147483648) begin
				sat = 32'sh80000000;
			end else begin
				sat = sum[31:0];
			end
		end

		assign target_next[k] = tick ? sat : tgt_q[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tgt_q[k] <= 32'sd0;
			end else begin
				tgt_q[k] <= target_next[k];
			end
		end
	end
endmodule
`default_nettype wire

[design/framed_csv_wheel_command_receiver_core.sv]
// Path: an accepted item is held in the input register (s1), then its result in the result register
// until taken; parser, damping lanes and watchdog compute the result combinationally from s1.
// Throughput: one item per cycle while results are taken as they appear.
// A result waiting in the output register stalls the input once the input register is also full.
// Reset (arst_n low, asynchronous): parser idle, commands and targets zero, last frame time 0,
// gain 6554 and timeout 100000 us; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "framed_csv_wheel_command_receiver_core_assert.svh"
module framed_csv_wheel_command_receiver_core #(
	parameter int BODY_BYTES      = 63,
	parameter int FRACTION_DIGITS = 5,
	parameter int CHANNELS        = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [fcwr_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	fcwr_in_if.sink                              in_ch,
	fcwr_out_if.source                           out_ch
);
	import fcwr_pkg::*;

	logic [16:0] alpha;
	logic [31:0] timeout;

	logic       valid_s1;
	fcwr_item_t item_s1;
	logic       adv;
	logic       in_ready;
	logic       is_close;

	logic signed [31:0] raw_cmd [CHANNELS];
	logic signed [31:0] target_next [CHANNELS];
	logic signed [31:0] tgt_sel [NUM_WHEELS];

	logic [31:0] lft_q;
	logic [31:0] lft_next;
	logic [31:0] age;
	logic        alive;

	logic               out_valid_q;
	logic signed [31:0] res_tgt_q [NUM_WHEELS];
	logic               res_alive_q;
	logic               res_done_q;

	fcwr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.alpha   (alpha),
		.timeout (timeout)
	);

	// item in s1 moves on when the result register is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ready = !valid_s1 || adv;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ready) begin
			item_s1.cmd     <= in_ch.cmd;
			item_s1.rx_byte <= in_ch.rx_byte;
			item_s1.now_us  <= in_ch.now_us;
		end
	end

	fcwr_parse #(
		.BODY_BYTES      (BODY_BYTES),
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.CHANNELS        (CHANNELS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.item    (item_s1),
		.raw_cmd (raw_cmd)
	);

	fcwr_damp #(
		.CHANNELS (CHANNELS)
	) u_damp (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (adv && item_s1.cmd),
		.alpha       (alpha),
		.raw_cmd     (raw_cmd),
		.target_next (target_next)
	);

	// closing byte refreshes the watchdog even outside a frame
	assign is_close = !item_s1.cmd && (item_s1.rx_byte == CH_CLOSE);
	assign lft_next = is_close ? item_s1.now_us : lft_q;
	assign age      = 32'(item_s1.now_us - lft_next);
	assign alive    = (age <= timeout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lft_q <= 32'd0;
		end else if (adv) begin
			lft_q <= lft_next;
		end
	end

	for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_wheel
		if (k < CHANNELS) begin : g_used
			assign tgt_sel[k] = target_next[k];
		end else begin : g_unused
			assign tgt_sel[k] = 32'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_tgt_q   <= tgt_sel;
			res_alive_q <= alive;
			res_done_q  <= is_close;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.target_front_left  = res_tgt_q[0];
	assign out_ch.target_front_right = res_tgt_q[1];
	assign out_ch.target_rear_left   = res_tgt_q[2];
	assign out_ch.target_rear_right  = res_tgt_q[3];
	assign out_ch.link_alive         = res_alive_q;
	assign out_ch.frame_done         = res_done_q;

	`FCWR_ASSERT_NOW(a_stall_cause, !in_ch.ready, valid_s1 && out_valid_q && !out_ch.ready, "input stalled without a blocked result")
	`FCWR_ASSERT_NEXT(a_close_alive, adv && is_close, out_valid_q && res_done_q && res_alive_q, "closing item must report done and alive")
	`FCWR_ASSERT_NEXT(a_tick_not_done, adv && item_s1.cmd, out_valid_q && !res_done_q, "tick item reported frame done")
endmodule
`default_nettype wire

[tb/tb_framed_csv_wheel_command_receiver_core.sv]
// Testbench for the framed CSV wheel command receiver: random framed traffic, ticks and gains
`timescale 1ns / 1ps
module tb_framed_csv_wheel_command_receiver_core;
	import fcwr_pkg::*;

	localparam int BODY_LIMIT     = 63;
	localparam int FRAC_KEEP      = 5;
	localparam int PHASE_ITEMS    = 205;
	localparam int DRAIN_CYCLES   = 4;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [31:0] fl;
		logic [31:0] fr;
		logic [31:0] rl;
		logic [31:0] rr;
		logic        alive;
		logic        done;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	fcwr_in_if  in_ch();
	fcwr_out_if out_ch();

	logic       drv_valid = 1'b0;
	fcwr_item_t drv_item = '0;
	logic       rcv_ready = 1'b0;

	assign in_ch.valid   = drv_valid;
	assign in_ch.cmd     = drv_item.cmd;
	assign in_ch.rx_byte = drv_item.rx_byte;
	assign in_ch.now_us  = drv_item.now_us;
	assign out_ch.ready  = rcv_ready;

	framed_csv_wheel_command_receiver_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// stimulus and expectations
	fcwr_item_t  rx_items[$];
	report_t     expected_reports[$];
	int unsigned queued_items = 0;
	logic [31:0] sim_now = '0;
	int          errors = 0;

	// receiver model state
	logic [16:0]  gain_q16 = ALPHA_RESET;
	logic [31:0]  timeout_us = TIMEOUT_RESET;
	bit           p_in_frame = 1'b0;
	int unsigned  p_body_cnt = 0;
	bit           p_text_done = 1'b0;
	int unsigned  p_tok_idx = 0;
	fcwr_phase_t  p_phase = PH_IDLE;
	bit           p_neg = 1'b0;
	int unsigned  p_int = 0;
	bit           p_int_sat = 1'b0;
	int unsigned  p_frac = 0;
	int unsigned  p_frac_nd = 0;
	logic [31:0]  p_pend[NUM_WHEELS] = '{default: '0};
	logic [31:0]  p_raw[NUM_WHEELS] = '{default: '0};
	logic [31:0]  p_tgt[NUM_WHEELS] = '{default: '0};
	logic [31:0]  p_last_frame = '0;

	function automatic logic [31:0] token_q16();
		longint unsigned whole;
		longint unsigned den;
		longint unsigned frac;
		longint unsigned mag;
		int k;
		whole = p_int_sat ? 64'd65535 : 64'(p_int);
		den = 1;
		for (k = 0; k < p_frac_nd; k++) den = den * 10;
		frac = (64'(p_frac) * 131072 + den) / (2 * den);
		mag = whole * 65536 + frac;
		if (p_neg) begin
			if (mag > 64'h80000000) mag = 64'h80000000;
			return 32'(64'd0 - mag);
		end
		if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
		return mag[31:0];
	endfunction

	function automatic void close_token();
		if (p_phase != PH_IDLE) begin
			if (p_tok_idx < NUM_WHEELS) begin
				p_pend[p_tok_idx] = token_q16();
				p_tok_idx++;
			end
			p_phase = PH_IDLE;
		end
	endfunction

	function automatic void restart_text();
		p_body_cnt = 0;
		p_text_done = 1'b0;
		p_tok_idx = 0;
		p_phase = PH_IDLE;
	endfunction

	function automatic void parse_body_char(input logic [7:0] c);
		bit is_digit;
		bit take_int;
		int unsigned v;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		take_int = 1'b0;
		if (c == CH_COMMA) begin
			close_token();
			return;
		end
		if (p_phase == PH_IDLE) begin
			p_phase = PH_START;
			p_neg = 1'b0;
			p_int = 0;
			p_int_sat = 1'b0;
			p_frac = 0;
			p_frac_nd = 0;
		end
		case (p_phase)
			PH_START: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					p_neg = (c == CH_MINUS);
					p_phase = PH_INT;
				end else begin
					p_phase = PH_INT;
					take_int = 1'b1;
				end
			end
			PH_INT: take_int = 1'b1;
			PH_FRAC: begin
				if (is_digit) begin
					if (p_frac_nd < FRAC_KEEP) begin
						p_frac = p_frac * 10 + (c - CH_ZERO);
						p_frac_nd++;
					end
				end else begin
					p_phase = PH_STOP;
				end
			end
			default: ;
		endcase
		if (take_int) begin
			if (is_digit) begin
				v = p_int * 10 + (c - CH_ZERO);
				if (p_int_sat || v > 65535) begin
					p_int_sat = 1'b1;
					p_int = 65535;
				end else begin
					p_int = v;
				end
			end else if (c == CH_DOT) begin
				p_phase = PH_FRAC;
			end else begin
				p_phase = PH_STOP;
			end
		end
	endfunction

	function automatic void damp_targets();
		longint gain;
		longint diff;
		longint step;
		longint t;
		gain = (gain_q16 > ALPHA_ONE) ? 64'sd65536 : longint'(gain_q16);
		for (int i = 0; i < NUM_WHEELS; i++) begin
			diff = longint'($signed(p_raw[i])) - longint'($signed(p_tgt[i]));
			// floor division after a half-LSB bias rounds ties upward
			step = (diff * gain + 32768) >>> 16;
			t = longint'($signed(p_tgt[i])) + step;
			if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
			if (t < -64'sh80000000) t = -64'sh80000000;
			p_tgt[i] = 32'(t);
		end
	endfunction

	function automatic report_t advance_receiver(input fcwr_item_t it);
		report_t rep;
		logic [31:0] elapsed;
		rep.done = 1'b0;
		if (it.cmd) begin
			damp_targets();
		end else if (it.rx_byte == CH_OPEN) begin
			p_in_frame = 1'b1;
			restart_text();
		end else if (it.rx_byte == CH_CLOSE) begin
			if (p_in_frame) begin
				close_token();
				for (int i = 0; i < NUM_WHEELS; i++)
					if (i < p_tok_idx) p_raw[i] = p_pend[i];
				p_in_frame = 1'b0;
				restart_text();
			end
			p_last_frame = it.now_us;
			rep.done = 1'b1;
		end else if (p_in_frame && !p_text_done && p_body_cnt < BODY_LIMIT) begin
			p_body_cnt++;
			if (it.rx_byte == CH_NUL) begin
				close_token();
				p_text_done = 1'b1;
			end else begin
				parse_body_char(it.rx_byte);
			end
		end
		elapsed = it.now_us - p_last_frame;
		rep.fl = p_tgt[0];
		rep.fr = p_tgt[1];
		rep.rl = p_tgt[2];
		rep.rr = p_tgt[3];
		rep.alive = (elapsed <= timeout_us);
		return rep;
	endfunction

	// sender: bursts of items with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive
		bit         take;
		logic       nv;
		fcwr_item_t nxt;
		int         b;
		int         g;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_item <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			take = drv_valid && in_ch.ready;
			if (take) expected_reports.push_back(advance_receiver(drv_item));
			nv = drv_valid;
			nxt = drv_item;
			b = burst_left;
			g = gap_left;
			if (!drv_valid || take) begin
				nv = 1'b0;
				if (g > 0) begin
					g--;
				end else if (rx_items.size() > 0) begin
					nxt = rx_items.pop_front();
					nv = 1'b1;
					if (b > 0) b--;
					if (b == 0) begin
						b = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
						g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
			end
			drv_valid <= nv;
			drv_item <= nxt;
			burst_left <= b;
			gap_left <= g;
		end
	end

	// receiver: random stall patterns, result checks and an idle watchdog
	int stall_mode = 0;
	int mode_left = 0;
	int idle_cycles = 0;

	always @(posedge clk or negedge arst_n) begin : observe
		report_t got;
		report_t want;
		int      m;
		int      ml;
		logic    r;
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			idle_cycles <= 0;
		end else begin
			if (out_ch.valid && rcv_ready) begin
				got.fl = out_ch.target_front_left;
				got.fr = out_ch.target_front_right;
				got.rl = out_ch.target_rear_left;
				got.rr = out_ch.target_rear_right;
				got.alive = out_ch.link_alive;
				got.done = out_ch.frame_done;
				if (expected_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: fl=%h fr=%h rl=%h rr=%h alive=%b done=%b",
							got.fl, got.fr, got.rl, got.rr, got.alive, got.done);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected fl=%h fr=%h rl=%h rr=%h alive=%b done=%b",
								want.fl, want.fr, want.rl, want.rr, want.alive, want.done);
							$display("          actual   fl=%h fr=%h rl=%h rr=%h alive=%b done=%b",
								got.fl, got.fr, got.rl, got.rr, got.alive, got.done);
						end
					end
				end
			end
			m = stall_mode;
			ml = mode_left;
			if (ml == 0) begin
				m = $urandom_range(0, 4);
				ml = $urandom_range(16, 96);
			end else begin
				ml--;
			end
			case (m)
				1: r = $urandom_range(0, 1);
				2: r = ($urandom_range(0, 3) == 0);
				3: r = (ml % 5) < 3;
				4: r = (ml % 12) == 0;
				default: r = 1'b1;
			endcase
			rcv_ready <= r;
			stall_mode <= m;
			mode_left <= ml;
			if ((drv_valid && in_ch.ready) || (out_ch.valid && rcv_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_framed_csv_wheel_command_receiver_core failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_item(input logic cmd, input logic [7:0] b);
		fcwr_item_t it;
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 15) sim_now = sim_now + $urandom_range(0, 300);
		else if (r < 19) sim_now = sim_now + $urandom_range(0, 250000);
		else sim_now = $urandom();
		it.cmd = cmd;
		it.rx_byte = b;
		it.now_us = sim_now;
		rx_items.push_back(it);
		queued_items++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(1'b0, b);
	endtask

	task automatic push_tick();
		push_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	task automatic send_number();
		int unsigned r;
		int unsigned n;
		if ($urandom_range(0, 3) == 0) begin
			r = $urandom_range(0, 5);
			push_byte(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
		end
		r = $urandom_range(0, 3);
		if (r == 0) push_byte(CH_PLUS);
		else if (r == 1) push_byte(CH_MINUS);
		// a few long integer parts drive the saturation path
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
		repeat (n) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 2) != 0) begin
			push_byte(CH_DOT);
			repeat ($urandom_range(0, 7)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame();
		int unsigned ntok;
		push_byte(CH_OPEN);
		if ($urandom_range(0, 7) == 0) push_byte(CH_COMMA);
		ntok = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : NUM_WHEELS;
		for (int k = 0; k < ntok; k++) begin
			if (k > 0) repeat (($urandom_range(0, 4) == 0) ? 2 : 1) push_byte(CH_COMMA);
			send_number();
		end
		if ($urandom_range(0, 7) == 0) push_byte(CH_COMMA);
		case ($urandom_range(0, 19))
			0: begin
				push_byte(CH_NUL);
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
			end
			1: begin
				// overlong body: bytes past the limit must be dropped
				repeat ($urandom_range(60, 75))
					push_byte(($urandom_range(0, 3) == 0) ? CH_COMMA
						: CH_ZERO + 8'($urandom_range(0, 9)));
			end
			2: begin
				push_byte(CH_OPEN);
				send_number();
			end
			default: ;
		endcase
		push_byte(CH_CLOSE);
		repeat ($urandom_range(0, 6)) push_tick();
	endtask

	task automatic send_traffic(input int unsigned count);
		int unsigned start;
		int unsigned r;
		start = queued_items;
		while (queued_items - start < count) begin
			r = $urandom_range(0, 19);
			if (r < 15) send_frame();
			else if (r < 17) repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
			else repeat ($urandom_range(1, 8)) push_tick();
		end
	endtask

	task automatic wait_idle();
		while (rx_items.size() != 0 || drv_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == CFG_IDX_ALPHA) gain_q16 = value[16:0];
		else timeout_us = value;
	endtask

	task automatic set_config(input logic [31:0] gain, input logic [31:0] timeout);
		wait_idle();
		write_reg(CFG_IDX_ALPHA, gain);
		write_reg(CFG_IDX_TIMEOUT, timeout);
		@(negedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// closing byte outside a frame with time near wrap, stray byte, restart,
		// saturating integer, dropped sixth fraction digit, exponent, junk token,
		// extra token and NUL end, then two ticks at the reset gain
		sim_now = 32'hFFFFFFF0;
		push_text("><9<-70000.5,,.000008,\t1e3,x,5");
		push_byte(CH_NUL);
		push_byte(CH_CLOSE);
		push_tick();
		push_tick();

		set_config(32'h10000, 32'd0);
		send_traffic(PHASE_ITEMS);
		set_config(32'd0, 32'hFFFFFFFF);
		send_traffic(PHASE_ITEMS);
		set_config(32'h1FFFF, 32'd1000);
		send_traffic(PHASE_ITEMS);
		// half gain makes rounding ties common
		set_config(32'h8000, 32'd100000);
		send_traffic(PHASE_ITEMS);
		set_config(32'd1, 32'd50);
		send_traffic(PHASE_ITEMS);
		set_config($urandom_range(0, 32'h1FFFF), $urandom_range(0, 300000));
		send_traffic(PHASE_ITEMS);
		set_config($urandom_range(0, 32'h1FFFF), $urandom());
		send_traffic(PHASE_ITEMS);
		set_config(32'(ALPHA_RESET), TIMEOUT_RESET);
		send_traffic(PHASE_ITEMS);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("tb_framed_csv_wheel_command_receiver_core passed");
		end else begin
			$display("tb_framed_csv_wheel_command_receiver_core failed");
		end
		$finish;
	end
endmodule
